// ----- rtl/cle_pkg.sv -----
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types, codes and key tables for the cursor line editor.
// ----------------------------------------------------------------------------
package cle_pkg;

  localparam int unsigned CHAR_W = 16;

  // Input operation codes (tuser on the input side)
  typedef enum logic [1:0] {
    OP_KEY     = 2'd0,
    OP_OPEN    = 2'd1,
    OP_PRELOAD = 2'd2,
    OP_UNUSED  = 2'd3
  } op_e;

  // Result action codes (tuser on the output side)
  typedef enum logic [2:0] {
    ACT_EDIT    = 3'd0,
    ACT_IGNORED = 3'd1,
    ACT_CANCEL  = 3'd2,
    ACT_CHAR    = 3'd3,
    ACT_EMPTY   = 3'd4
  } act_e;

  // Key codes
  localparam logic [15:0] KEY_CANCEL   = 16'h00F0;
  localparam logic [15:0] KEY_COMMIT   = 16'h00F1;
  localparam logic [15:0] KEY_ENTER    = 16'h000D;
  localparam logic [15:0] KEY_ENTER2   = 16'h0D0D;
  localparam logic [15:0] KEY_BKSP     = 16'h00F2;
  localparam logic [15:0] KEY_DEL      = 16'h00F3;
  localparam logic [15:0] KEY_CAPS     = 16'h00F4;
  localparam logic [15:0] KEY_LEFT     = 16'h00F7;
  localparam logic [15:0] KEY_RIGHT    = 16'h00F8;
  localparam logic [15:0] KEY_CAND_LO  = 16'hF101;
  localparam logic [15:0] KEY_CAND_HI  = 16'hF105;
  localparam logic [15:0] KEY_ACC_LO   = 16'hF200;
  localparam logic [15:0] KEY_ACC_HI   = 16'hF211;
  localparam logic [15:0] CHAR_MIN     = 16'h0020;

  localparam int unsigned ACC_N = 17;

  localparam logic [15:0] ACCENT_LOWER [ACC_N] = '{
    16'h00E1, 16'h00E4, 16'h010D, 16'h010F, 16'h00E9, 16'h00ED,
    16'h013A, 16'h013E, 16'h0148, 16'h00F3, 16'h00F4, 16'h0155,
    16'h0161, 16'h0165, 16'h00FA, 16'h00FD, 16'h017E
  };
  localparam logic [15:0] ACCENT_UPPER [ACC_N] = '{
    16'h00C1, 16'h00C4, 16'h010C, 16'h010E, 16'h00C9, 16'h00CD,
    16'h0139, 16'h013D, 16'h0147, 16'h00D3, 16'h00D4, 16'h0154,
    16'h0160, 16'h0164, 16'h00DA, 16'h00DD, 16'h017D
  };

  // Key classes after decode
  typedef enum logic [3:0] {
    K_CANCEL,
    K_COMMIT,
    K_BKSP,
    K_DEL,
    K_CAPS,
    K_LEFT,
    K_RIGHT,
    K_IGNORE,
    K_INSERT
  } key_kind_e;

  typedef struct packed {
    key_kind_e          kind;
    logic [CHAR_W-1:0]  ch;
  } key_dec_t;

endpackage

// ----- rtl/cle_store.sv -----
// ----------------------------------------------------------------------------
// cle_store
// Text buffer memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cle_store #(
  parameter int unsigned DEPTH = 63,
  parameter int unsigned AW    = 6
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [cle_pkg::CHAR_W-1:0]  wdata_i,
  input  logic                        re_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [cle_pkg::CHAR_W-1:0]  rdata_o
);

  logic [cle_pkg::CHAR_W-1:0] mem_q [DEPTH];

  // Write one word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read one word, hold data while not reading
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- rtl/cle_decode.sv -----
// ----------------------------------------------------------------------------
// cle_decode
// Key event classifier: maps a key code and the caps flag to a key class and
// the character to insert.
// ----------------------------------------------------------------------------
module cle_decode (
  input  logic [15:0]       key_i,
  input  logic              caps_i,
  output cle_pkg::key_dec_t dec_o
);

  logic [15:0] plain_ch;
  logic [4:0]  acc_idx;

  assign acc_idx = key_i[4:0];

  // Pick a byte of packed pairs, or use low keys whole
  always_comb begin
    if (key_i[15:8] != 8'h00) begin
      plain_ch = caps_i ? {8'h00, key_i[15:8]} : {8'h00, key_i[7:0]};
    end else begin
      plain_ch = key_i;
    end
  end

  // Classify in priority order
  always_comb begin
    dec_o.kind = cle_pkg::K_IGNORE;
    dec_o.ch   = '0;
    priority if (key_i == cle_pkg::KEY_CANCEL) begin
      dec_o.kind = cle_pkg::K_CANCEL;
    end else if (key_i == cle_pkg::KEY_COMMIT || key_i == cle_pkg::KEY_ENTER ||
                 key_i == cle_pkg::KEY_ENTER2) begin
      dec_o.kind = cle_pkg::K_COMMIT;
    end else if (key_i == cle_pkg::KEY_BKSP) begin
      dec_o.kind = cle_pkg::K_BKSP;
    end else if (key_i == cle_pkg::KEY_DEL) begin
      dec_o.kind = cle_pkg::K_DEL;
    end else if (key_i == cle_pkg::KEY_CAPS) begin
      dec_o.kind = cle_pkg::K_CAPS;
    end else if (key_i == cle_pkg::KEY_LEFT) begin
      dec_o.kind = cle_pkg::K_LEFT;
    end else if (key_i == cle_pkg::KEY_RIGHT) begin
      dec_o.kind = cle_pkg::K_RIGHT;
    end else if (key_i >= cle_pkg::KEY_CAND_LO && key_i < cle_pkg::KEY_CAND_HI) begin
      dec_o.kind = cle_pkg::K_IGNORE;
    end else if (key_i >= cle_pkg::KEY_ACC_LO && key_i < cle_pkg::KEY_ACC_HI) begin
      dec_o.kind = cle_pkg::K_INSERT;
      dec_o.ch   = caps_i ? cle_pkg::ACCENT_UPPER[acc_idx] : cle_pkg::ACCENT_LOWER[acc_idx];
    end else if (plain_ch < cle_pkg::CHAR_MIN) begin
      dec_o.kind = cle_pkg::K_IGNORE;
    end else begin
      dec_o.kind = cle_pkg::K_INSERT;
      dec_o.ch   = plain_ch;
    end
  end

endmodule

// ----- rtl/cursor_line_editor.sv -----
// ----------------------------------------------------------------------------
// cursor_line_editor
// Single-line UTF-16 text editor with cursor, caps, full and session flags.
// ----------------------------------------------------------------------------
//  channel   dir  tdata (low bit up)                         tuser      tlast
//  s_axis    in   key_code[15:0], preload_char[31:16]        operation  -
//  m_axis    out  text_char, cursor_pos, text_length, caps,  action     last
//                 full, session_active, zero pad
//
//  A plain item passes from accept to ST_RESP, which loads the result. An
//  insert adds the ST_INSW write, after ST_SHUP moves the text above the
//  cursor up when needed; a delete that closes a gap runs ST_SHDN first.
//  A commit reads each character through ST_RD and ST_CAP. The single
//  memory, with one write and one read port, paces shift and readout.
//  Reset clears length, cursor and flags; buffer contents stay undefined.
//  The result register frees the input side: a new word is taken while the
//  previous result waits; a stalled output only holds the sequencer.
// ----------------------------------------------------------------------------
module cursor_line_editor #(
  parameter int unsigned MAX_CHARS = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // key_code[15:0], preload_char[31:16]
  input  logic [1:0]  s_axis_tuser,   // operation[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // text_char[15:0], cursor_pos[21:16],
                                      // text_length[27:22], caps_on[28],
                                      // full_flag[29], session_active[30], 0[31]
  output logic [2:0]  m_axis_tuser,   // action[2:0]
  output logic        m_axis_tlast    // last
);

  localparam int unsigned LW = $clog2(MAX_CHARS + 1);
  localparam int unsigned AW = $clog2(MAX_CHARS);
  localparam int unsigned CW = cle_pkg::CHAR_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHUP,
    ST_INSW,
    ST_SHDN,
    ST_RD,
    ST_CAP,
    ST_RESP
  } state_e;

  state_e           state_q, state_d;
  logic [LW-1:0]    len_q, len_d;
  logic [LW-1:0]    cur_q, cur_d;
  logic [LW-1:0]    ptr_q, ptr_d;
  logic             caps_q, caps_d;
  logic             full_q, full_d;
  logic             act_q, act_d;
  logic             rdv_q, rdv_d;
  cle_pkg::act_e    res_q, res_d;
  logic [CW-1:0]    chr_q, chr_d;

  logic             m_valid_q;
  logic [31:0]      m_data_q;
  logic [2:0]       m_user_q;
  logic             m_last_q;

  logic             we, re;
  logic [AW-1:0]    waddr, raddr;
  logic [CW-1:0]    wdata, rdata;

  logic             load;
  cle_pkg::act_e    ld_act;
  logic [CW-1:0]    ld_char;
  logic             ld_last;
  logic             slot_free;
  logic             accept;

  cle_pkg::key_dec_t dec;
  cle_pkg::op_e      op;
  logic [CW-1:0]     key_code, pre_char;

  logic [LW-1:0]    ptr_m1, ptr_m2, ptr_p1, ptr_p2, len_m1, cur_m1;
  logic [LW:0]      ptr_x, cur_p1_x;

  assign op       = cle_pkg::op_e'(s_axis_tuser);
  assign key_code = s_axis_tdata[15:0];
  assign pre_char = s_axis_tdata[31:16];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !m_valid_q || m_axis_tready;

  assign ptr_m1   = ptr_q - LW'(1);
  assign ptr_m2   = ptr_q - LW'(2);
  assign ptr_p1   = ptr_q + LW'(1);
  assign ptr_p2   = ptr_q + LW'(2);
  assign len_m1   = len_q - LW'(1);
  assign cur_m1   = cur_q - LW'(1);
  assign ptr_x    = {1'b0, ptr_q};
  assign cur_p1_x = {1'b0, cur_q} + (LW+1)'(1);

  cle_decode u_decode (
    .key_i  (key_code),
    .caps_i (caps_q),
    .dec_o  (dec)
  );

  cle_store #(
    .DEPTH (MAX_CHARS),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Sequencer: decode the word, then shift, write or read out the buffer
  always_comb begin
    state_d = state_q;
    len_d   = len_q;
    cur_d   = cur_q;
    ptr_d   = ptr_q;
    caps_d  = caps_q;
    full_d  = full_q;
    act_d   = act_q;
    rdv_d   = rdv_q;
    res_d   = res_q;
    chr_d   = chr_q;
    we      = 1'b0;
    waddr   = '0;
    wdata   = '0;
    re      = 1'b0;
    raddr   = '0;
    load    = 1'b0;
    ld_act  = res_q;
    ld_char = '0;
    ld_last = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RESP;
          res_d   = cle_pkg::ACT_EDIT;
          rdv_d   = 1'b0;
          unique case (op)
            cle_pkg::OP_KEY: begin
              if (!act_q) begin
                res_d = cle_pkg::ACT_IGNORED;
              end else begin
                unique case (dec.kind)
                  cle_pkg::K_CANCEL: begin
                    act_d = 1'b0;
                    res_d = cle_pkg::ACT_CANCEL;
                  end
                  cle_pkg::K_COMMIT: begin
                    act_d = 1'b0;
                    if (len_q == '0) begin
                      res_d = cle_pkg::ACT_EMPTY;
                    end else begin
                      ptr_d   = '0;
                      state_d = ST_RD;
                    end
                  end
                  cle_pkg::K_BKSP: begin
                    if (cur_q != '0) begin
                      cur_d  = cur_m1;
                      len_d  = len_m1;
                      full_d = 1'b0;
                      if (cur_q < len_q) begin
                        ptr_d   = cur_m1;
                        state_d = ST_SHDN;
                      end
                    end
                  end
                  cle_pkg::K_DEL: begin
                    if (cur_q < len_q) begin
                      len_d  = len_m1;
                      full_d = 1'b0;
                      if (cur_q < len_m1) begin
                        ptr_d   = cur_q;
                        state_d = ST_SHDN;
                      end
                    end
                  end
                  cle_pkg::K_CAPS: begin
                    caps_d = !caps_q;
                    full_d = 1'b0;
                  end
                  cle_pkg::K_LEFT: begin
                    if (cur_q != '0) begin
                      cur_d = cur_m1;
                    end
                    full_d = 1'b0;
                  end
                  cle_pkg::K_RIGHT: begin
                    if (cur_q < len_q) begin
                      cur_d = cur_q + LW'(1);
                    end
                    full_d = 1'b0;
                  end
                  cle_pkg::K_INSERT: begin
                    chr_d = dec.ch;
                    if (len_q == LW'(MAX_CHARS)) begin
                      full_d = 1'b1;
                    end else if (len_q > cur_q) begin
                      ptr_d   = len_q;
                      state_d = ST_SHUP;
                    end else begin
                      state_d = ST_INSW;
                    end
                  end
                  default: begin
                    res_d = cle_pkg::ACT_IGNORED;
                  end
                endcase
              end
            end
            cle_pkg::OP_OPEN: begin
              if (act_q) begin
                res_d = cle_pkg::ACT_IGNORED;
              end else begin
                len_d  = '0;
                cur_d  = '0;
                caps_d = 1'b0;
                full_d = 1'b0;
                act_d  = 1'b1;
              end
            end
            cle_pkg::OP_PRELOAD: begin
              if (act_q && pre_char != '0 && len_q != LW'(MAX_CHARS)) begin
                we    = 1'b1;
                waddr = len_q[AW-1:0];
                wdata = pre_char;
                len_d = len_q + LW'(1);
                cur_d = len_q + LW'(1);
              end else begin
                res_d = cle_pkg::ACT_IGNORED;
              end
            end
            default: begin
              res_d = cle_pkg::ACT_IGNORED;
            end
          endcase
        end
      end

      // Move characters up one place, from the end down to the cursor
      ST_SHUP: begin
        if (!rdv_q) begin
          re    = 1'b1;
          raddr = ptr_m1[AW-1:0];
          rdv_d = 1'b1;
        end else begin
          we    = 1'b1;
          waddr = ptr_q[AW-1:0];
          wdata = rdata;
          ptr_d = ptr_m1;
          if (ptr_x > cur_p1_x) begin
            re    = 1'b1;
            raddr = ptr_m2[AW-1:0];
          end else begin
            state_d = ST_INSW;
          end
        end
      end

      // Drop the new character in at the cursor
      ST_INSW: begin
        we      = 1'b1;
        waddr   = cur_q[AW-1:0];
        wdata   = chr_q;
        len_d   = len_q + LW'(1);
        cur_d   = cur_q + LW'(1);
        full_d  = 1'b0;
        state_d = ST_RESP;
      end

      // Move characters down one place, closing the gap (length already new)
      ST_SHDN: begin
        if (!rdv_q) begin
          re    = 1'b1;
          raddr = ptr_p1[AW-1:0];
          rdv_d = 1'b1;
        end else begin
          we    = 1'b1;
          waddr = ptr_q[AW-1:0];
          wdata = rdata;
          ptr_d = ptr_p1;
          if (ptr_p1 < len_q) begin
            re    = 1'b1;
            raddr = ptr_p2[AW-1:0];
          end else begin
            state_d = ST_RESP;
          end
        end
      end

      // Commit readout: fetch one character
      ST_RD: begin
        re      = 1'b1;
        raddr   = ptr_q[AW-1:0];
        state_d = ST_CAP;
      end

      // Commit readout: hand the character to the output register
      ST_CAP: begin
        if (slot_free) begin
          load    = 1'b1;
          ld_act  = cle_pkg::ACT_CHAR;
          ld_char = rdata;
          ld_last = (ptr_p1 == len_q);
          if (ptr_p1 == len_q) begin
            state_d = ST_IDLE;
          end else begin
            ptr_d   = ptr_p1;
            state_d = ST_RD;
          end
        end
      end

      ST_RESP: begin
        if (slot_free) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold sequencer state, pending character and the result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      len_q     <= '0;
      cur_q     <= '0;
      ptr_q     <= '0;
      caps_q    <= 1'b0;
      full_q    <= 1'b0;
      act_q     <= 1'b0;
      rdv_q     <= 1'b0;
      res_q     <= cle_pkg::ACT_EDIT;
      chr_q     <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_user_q  <= '0;
      m_last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      cur_q   <= cur_d;
      ptr_q   <= ptr_d;
      caps_q  <= caps_d;
      full_q  <= full_d;
      act_q   <= act_d;
      rdv_q   <= rdv_d;
      res_q   <= res_d;
      chr_q   <= chr_d;
      if (load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (load) begin
        m_data_q <= {1'b0, act_q, full_q, caps_q, 6'(len_q), 6'(cur_q), ld_char};
        m_user_q <= ld_act;
        m_last_q <= ld_last;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

  // Cursor stays within the text
  a_cur_in_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= len_q) else $error("cursor beyond text length");

  // Text never exceeds the buffer
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(MAX_CHARS)) else $error("text length beyond buffer");

  // Only commit readout gives results that are not the last of their word
  a_multi_is_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == cle_pkg::ACT_CHAR)
    else $error("non-final result outside commit");

  // Buffer shifting only runs inside an open session
  a_shift_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SHUP || state_q == ST_SHDN || state_q == ST_INSW |-> act_q)
    else $error("buffer edit without a session");

endmodule
